@@ rtl/two_class_priority_queue_with_ageout_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef TWO_CLASS_PRIORITY_QUEUE_WITH_AGEOUT_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_WITH_AGEOUT_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TCPQ_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCPQ_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcpq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the two-class priority queue.
// ---------------------------------------------------------------------------
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;
    localparam int PER_EDITION_DEF = 2;

    localparam int STAMP_BITS = 8;
    localparam int AGE_BITS   = 4;
    localparam logic [AGE_BITS-1:0] MAX_AGE_RESET = 4'd3;

    typedef enum logic [1:0] {
        KIND_ACCEPTED  = 2'd0,
        KIND_FULL      = 2'd1,
        KIND_PUBLISHED = 2'd2,
        KIND_SKIPPED   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_EXPIRE
    } t_state;

    // queue control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    // queue occupancy flags
    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/tcpq_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcpq_cell
// One queue slot: loads a new entry or takes its upstream neighbor's entry.
// ---------------------------------------------------------------------------
module tcpq_cell import tcpq_pkg::*; #(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_shift,
    input  logic [ID_BITS-1:0]    i_new_id,
    input  logic [STAMP_BITS-1:0] i_new_stamp,
    input  logic [ID_BITS-1:0]    i_nbr_id,
    input  logic [STAMP_BITS-1:0] i_nbr_stamp,
    output logic [ID_BITS-1:0]    o_id,
    output logic [STAMP_BITS-1:0] o_stamp
);

    logic [ID_BITS-1:0]    r_id;
    logic [STAMP_BITS-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id    <= i_new_id;
            r_stamp <= i_new_stamp;
        end else if (i_shift) begin
            r_id    <= i_nbr_id;
            r_stamp <= i_nbr_stamp;
        end
    end

    assign o_id    = r_id;
    assign o_stamp = r_stamp;

endmodule

@@ rtl/tcpq_chain.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcpq_chain
// FIFO built as a row of cells; cell 0 is the head, a pop shifts the row.
// ---------------------------------------------------------------------------
module tcpq_chain import tcpq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_ctl                i_ctl,
    input  logic [ID_BITS-1:0]    i_id,
    input  logic [STAMP_BITS-1:0] i_stamp,
    output t_q_stat               o_stat,
    output logic [ID_BITS-1:0]    o_head_id,
    output logic [STAMP_BITS-1:0] o_head_stamp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  w_full;
    logic                  w_push;
    logic [ID_BITS-1:0]    w_id    [QUEUE_DEPTH+1];
    logic [STAMP_BITS-1:0] w_stamp [QUEUE_DEPTH+1];

    assign w_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push = i_ctl.push && !w_full;

    // nothing ever shifts in past the tail
    assign w_id[QUEUE_DEPTH]    = '0;
    assign w_stamp[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tcpq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (w_push && (r_count[IDX_W-1:0] == IDX_W'(g))),
            .i_shift     (i_ctl.pop),
            .i_new_id    (i_id),
            .i_new_stamp (i_stamp),
            .i_nbr_id    (w_id[g+1]),
            .i_nbr_stamp (w_stamp[g+1]),
            .o_id        (w_id[g]),
            .o_stamp     (w_stamp[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop && (r_count != '0)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.one   = (r_count == CNT_W'(1));
    assign o_stat.full  = w_full;
    assign o_head_id    = w_id[0];
    assign o_head_stamp = w_stamp[0];

endmodule

@@ rtl/two_class_priority_queue_with_ageout_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_class_priority_queue_with_ageout_top
// Strict-priority two-class queue of item handles with age expiry.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low. i_func = 0 submits i_item_id to class i_priority_req;
//   i_func = 1 closes the current edition.
//   Result channel: o_valid marks each result beat for exactly one cycle;
//   the receiver cannot stall, so every result is taken when shown.
//   Config channel: i_cfg_valid/o_cfg_ready carry max_age (always ready);
//   write it only while busy is low.
// Sequencing:
//   Submit: the result is registered and shows in the cycle after the
//   command; busy stays low, so a new command may follow every cycle.
//   Close: one published result per cycle, urgent head first, up to
//   PER_EDITION of them (or one skipped result), then an expiry sweep that
//   drops one head entry per class per cycle until no head has expired.
// Reset: counts and edition clear, max_age loads 3; queue cells hold no reset.
// ---------------------------------------------------------------------------
module two_class_priority_queue_with_ageout_top import tcpq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int PER_EDITION = PER_EDITION_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic                i_priority_req,
    input  logic [ID_BITS-1:0]  i_item_id,
    // result channel
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [ID_BITS-1:0]  o_out_id,
    output logic                o_from_class,
    output logic                o_last,
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [AGE_BITS-1:0] i_cfg_data
);

    localparam int PC_W = (PER_EDITION > 1) ? $clog2(PER_EDITION) : 1;

    t_state                r_state, n_state;
    logic [PC_W-1:0]       r_pop_cnt, n_pop_cnt;
    logic [STAMP_BITS-1:0] r_edition, n_edition;
    logic [AGE_BITS-1:0]   r_max_age;

    // registered result beat
    logic                  r_valid, n_valid;
    t_kind                 r_kind, n_kind;
    logic [ID_BITS-1:0]    r_out_id, n_out_id;
    logic                  r_from_class, n_from_class;
    logic                  r_last, n_last;

    // queue interfaces: index 0 urgent, 1 normal
    t_q_ctl                w_ctl [2];
    t_q_stat               w_stat [2];
    logic [ID_BITS-1:0]    w_head_id [2];
    logic [STAMP_BITS-1:0] w_head_stamp [2];
    logic [STAMP_BITS-1:0] w_age [2];
    logic                  w_drop [2];
    logic                  w_take_u;
    logic                  w_rem_empty;
    logic                  w_pop_last;

    for (genvar q = 0; q < 2; q++) begin : g_queue
        tcpq_chain #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .ID_BITS     (ID_BITS)
        ) u_chain (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[q]),
            .i_id         (i_item_id),
            .i_stamp      (r_edition),
            .o_stat       (w_stat[q]),
            .o_head_id    (w_head_id[q]),
            .o_head_stamp (w_head_stamp[q])
        );

        // 8-bit modular age is exact: entries go before age passes 16
        assign w_age[q]  = r_edition - w_head_stamp[q];
        assign w_drop[q] = !w_stat[q].empty &&
                           (w_age[q] > {{(STAMP_BITS-AGE_BITS){1'b0}}, r_max_age});
    end

    // pop source and whether this pop ends the close
    assign w_take_u    = !w_stat[0].empty;
    assign w_rem_empty = w_take_u ? (w_stat[0].one && w_stat[1].empty) : w_stat[1].one;
    assign w_pop_last  = w_rem_empty || (r_pop_cnt == PC_W'(PER_EDITION - 1));

    always_comb begin
        n_state      = r_state;
        n_pop_cnt    = r_pop_cnt;
        n_edition    = r_edition;
        n_valid      = 1'b0;
        n_kind       = r_kind;
        n_out_id     = r_out_id;
        n_from_class = r_from_class;
        n_last       = r_last;
        for (int q = 0; q < 2; q++) begin
            w_ctl[q] = '0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (!i_func) begin
                        // submit: answer right away, full class drops the item
                        w_ctl[i_priority_req].push = 1'b1;
                        n_valid      = 1'b1;
                        n_kind       = w_stat[i_priority_req].full ? KIND_FULL
                                                                   : KIND_ACCEPTED;
                        n_out_id     = i_item_id;
                        n_from_class = i_priority_req;
                        n_last       = 1'b1;
                    end else begin
                        n_pop_cnt = '0;
                        n_state   = ST_POP;
                    end
                end
            end
            ST_POP: begin
                n_valid = 1'b1;
                if (w_stat[0].empty && w_stat[1].empty) begin
                    // only reached on the first pop slot
                    n_kind       = KIND_SKIPPED;
                    n_out_id     = '0;
                    n_from_class = 1'b0;
                    n_last       = 1'b1;
                    n_edition    = r_edition + STAMP_BITS'(1);
                    n_state      = ST_EXPIRE;
                end else begin
                    w_ctl[0].pop = w_take_u;
                    w_ctl[1].pop = !w_take_u;
                    n_kind       = KIND_PUBLISHED;
                    n_out_id     = w_take_u ? w_head_id[0] : w_head_id[1];
                    n_from_class = !w_take_u;
                    n_last       = w_pop_last;
                    if (w_pop_last) begin
                        n_edition = r_edition + STAMP_BITS'(1);
                        n_state   = ST_EXPIRE;
                    end else begin
                        n_pop_cnt = r_pop_cnt + PC_W'(1);
                    end
                end
            end
            ST_EXPIRE: begin
                // one head entry per class per cycle; oldest sit at the head
                w_ctl[0].pop = w_drop[0];
                w_ctl[1].pop = w_drop[1];
                if (!w_drop[0] && !w_drop[1]) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pop_cnt <= '0;
            r_edition <= '0;
            r_max_age <= MAX_AGE_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pop_cnt <= n_pop_cnt;
            r_edition <= n_edition;
            r_valid   <= n_valid;
            if (i_cfg_valid) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_out_id     <= n_out_id;
        r_from_class <= n_from_class;
        r_last       <= n_last;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_out_id     = r_out_id;
    assign o_from_class = r_from_class;
    assign o_last       = r_last;

endmodule

@@ rtl/tcpq_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on command and result beats of the priority queue.
// ---------------------------------------------------------------------------
`include "two_class_priority_queue_with_ageout_top_macros.svh"

module tcpq_checker import tcpq_pkg::*; #(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_func,
    input logic               o_valid,
    input logic [1:0]         o_kind,
    input logic [ID_BITS-1:0] o_out_id,
    input logic               o_from_class,
    input logic               o_last
);

    `TCPQ_ASSERT_NXT(a_submit_answer, i_clk, i_rst_n, start && !busy && !i_func, o_valid && o_last && ((o_kind == KIND_ACCEPTED) || (o_kind == KIND_FULL)), "submit beat not answered next cycle")

    `TCPQ_ASSERT_NXT(a_close_busy, i_clk, i_rst_n, start && !busy && i_func, busy && !o_valid, "close did not raise busy")

    `TCPQ_ASSERT_NXT(a_publish_run, i_clk, i_rst_n, o_valid && !o_last, o_valid && (o_kind == KIND_PUBLISHED), "published run broken before last beat")

    `TCPQ_ASSERT_IMP(a_skip_shape, i_clk, i_rst_n, o_valid && (o_kind == KIND_SKIPPED), o_last && (o_out_id == '0) && !o_from_class, "skipped beat malformed")

endmodule

bind two_class_priority_queue_with_ageout_top tcpq_checker #(
    .ID_BITS (ID_BITS)
) u_tcpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .o_valid      (o_valid),
    .o_kind       (o_kind),
    .o_out_id     (o_out_id),
    .o_from_class (o_from_class),
    .o_last       (o_last)
);
